[sv/assert_macros.svh]
// Assertion macros used by the ringtone parser controller.
// Expects signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define RTP_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define RTP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define RTP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/rtp_pkg.sv]
// Package of the ringtone text note parser: constants and the
// controller/datapath command and status structs. No dependencies.
package rtp_pkg;

    localparam int CharW    = 8;
    localparam int AccW     = 10;
    localparam int DlenW    = 8;
    localparam int WholeW   = 18;
    localparam int DurW     = 19;
    localparam int NoteW    = 4;
    localparam int OctW     = 4;
    localparam int OutOctW  = 5;
    localparam int OffW     = 3;
    localparam int DivBits  = WholeW;
    localparam int CntW     = 5;

    localparam logic [AccW-1:0]   AccMax      = 10'd1023;
    localparam logic [DlenW-1:0]  DlenMax     = 8'd255;
    localparam logic [DlenW-1:0]  DlenReset   = 8'd4;
    localparam logic [OctW-1:0]   DoctReset   = 4'd6;
    localparam logic [WholeW-1:0] WholeReset  = 18'd3808;
    localparam logic [WholeW-1:0] MsPerMinute = 18'd60000;

    localparam logic [CharW-1:0] ChColon = 8'h3A;
    localparam logic [CharW-1:0] ChComma = 8'h2C;
    localparam logic [CharW-1:0] ChHash  = 8'h23;
    localparam logic [CharW-1:0] ChDot   = 8'h2E;
    localparam logic [CharW-1:0] ChZero  = 8'h30;
    localparam logic [CharW-1:0] ChThree = 8'h33;
    localparam logic [CharW-1:0] ChSeven = 8'h37;
    localparam logic [CharW-1:0] ChNine  = 8'h39;
    localparam logic [CharW-1:0] ChA     = 8'h61;
    localparam logic [CharW-1:0] ChB     = 8'h62;
    localparam logic [CharW-1:0] ChC     = 8'h63;
    localparam logic [CharW-1:0] ChD     = 8'h64;
    localparam logic [CharW-1:0] ChE     = 8'h65;
    localparam logic [CharW-1:0] ChF     = 8'h66;
    localparam logic [CharW-1:0] ChG     = 8'h67;
    localparam logic [CharW-1:0] ChO     = 8'h6F;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic finish;
    } rtp_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic div_note;
    } rtp_sts_t;

endpackage

[sv/rtp_ifs.sv]
// Channel interfaces of the ringtone parser: input characters, note
// results and the octave offset write. Depends on rtp_pkg.
interface rtp_in_if;
    logic                       valid;
    logic                       ready;
    logic [rtp_pkg::CharW-1:0]  song_char;
    logic                       end_of_song;
    logic                       keep_playing;
    modport source (output valid, song_char, end_of_song, keep_playing, input ready);
    modport sink (input valid, song_char, end_of_song, keep_playing, output ready);
endinterface

interface rtp_out_if;
    logic                         valid;
    logic                         ready;
    logic [rtp_pkg::NoteW-1:0]    note_code;
    logic [rtp_pkg::OutOctW-1:0]  octave;
    logic [rtp_pkg::DurW-1:0]     duration_ms;
    logic                         last_note;
    modport source (output valid, note_code, octave, duration_ms, last_note, input ready);
    modport sink (input valid, note_code, octave, duration_ms, last_note, output ready);
endinterface

interface rtp_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [rtp_pkg::OffW-1:0]  oct_shift;
    modport source (output valid, oct_shift, input ready);
    modport sink (input valid, oct_shift, output ready);
endinterface

[sv/rtp_dp.sv]
// Datapath of the ringtone parser: text parse state, bit-serial divider
// and result registers. Depends on rtp_pkg.
module rtp_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rtp_pkg::rtp_cmd_t            cmd,
    output rtp_pkg::rtp_sts_t            sts,
    input  logic [rtp_pkg::CharW-1:0]    song_char,
    input  logic                         end_of_song,
    input  logic                         keep_playing,
    input  logic                         cfg_we,
    input  logic [rtp_pkg::OffW-1:0]     cfg_offset,
    output logic [rtp_pkg::NoteW-1:0]    note_code,
    output logic [rtp_pkg::OutOctW-1:0]  octave,
    output logic [rtp_pkg::DurW-1:0]     duration_ms,
    output logic                         last_note
);

    typedef enum logic [15:0] {
        PH_SKIP_NAME = 16'h0001, PH_HDR_D = 16'h0002, PH_D_EQ = 16'h0004,
        PH_D_VAL = 16'h0008, PH_HDR_O = 16'h0010, PH_O_EQ = 16'h0020,
        PH_O_VAL = 16'h0040, PH_O_SEP = 16'h0080, PH_HDR_B = 16'h0100,
        PH_B_EQ = 16'h0200, PH_B_VAL = 16'h0400, PH_N_LEN = 16'h0800,
        PH_N_LETTER = 16'h1000, PH_N_SHARP = 16'h2000, PH_N_DOT = 16'h4000,
        PH_N_OCT = 16'h8000
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [rtp_pkg::AccW-1:0]      acc_reg, acc_next;
    logic [rtp_pkg::DlenW-1:0]     dlen_reg, dlen_next;
    logic [rtp_pkg::OctW-1:0]      doct_reg, doct_next;
    logic [rtp_pkg::WholeW-1:0]    whole_reg;
    logic [rtp_pkg::NoteW-1:0]     pnote_reg, pnote_next;
    logic [rtp_pkg::OctW-1:0]      poct_reg, poct_next;
    logic                          pdot_reg, pdot_next;
    logic                          stop_reg, stop_next;
    logic [rtp_pkg::OffW-1:0]      offset_reg;

    logic [rtp_pkg::AccW-1:0]      rem_reg;
    logic [rtp_pkg::WholeW-1:0]    quo_reg;
    logic [rtp_pkg::AccW-1:0]      dvsr_reg;
    logic [rtp_pkg::CntW-1:0]      cnt_reg;
    logic                          kind_note_reg;
    logic                          odot_reg;

    logic [rtp_pkg::NoteW-1:0]     onote_reg;
    logic [rtp_pkg::OutOctW-1:0]   ooct_reg;
    logic [rtp_pkg::DurW-1:0]      odur_reg;
    logic                          olast_reg;

    // Parse results for the item at the input.
    logic                          emit;
    logic                          emit_last;
    logic                          bpm_fire;
    logic [rtp_pkg::NoteW-1:0]     e_note;
    logic [rtp_pkg::OctW-1:0]      e_oct;
    logic                          e_dot;
    logic [rtp_pkg::AccW-1:0]      e_len;
    logic [rtp_pkg::AccW-1:0]      bpm_val;

    always_comb
    begin
        logic       redo;
        logic       term;
        logic       dig;
        logic [3:0] dval;
        logic [13:0] prod;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        dlen_next  = dlen_reg;
        doct_next  = doct_reg;
        pnote_next = pnote_reg;
        poct_next  = poct_reg;
        pdot_next  = pdot_reg;
        stop_next  = stop_reg;
        emit       = 1'b0;
        emit_last  = 1'b0;
        bpm_fire   = 1'b0;
        e_note     = pnote_reg;
        e_oct      = poct_reg;
        e_dot      = pdot_reg;
        e_len      = (acc_reg != '0) ? acc_reg : {2'b00, dlen_reg};
        bpm_val    = acc_reg;
        dig        = (song_char >= rtp_pkg::ChZero) && (song_char <= rtp_pkg::ChNine);
        dval       = 4'(song_char - rtp_pkg::ChZero);
        prod       = 14'({4'b0000, acc_reg} * 14'd10) + {10'd0, dval};
        redo       = 1'b1;
        term       = 1'b0;
        if (end_of_song)
        begin
            if (!stop_reg && (phase_reg == PH_N_LETTER || phase_reg == PH_N_SHARP ||
                              phase_reg == PH_N_DOT || phase_reg == PH_N_OCT))
            begin
                emit      = 1'b1;
                emit_last = 1'b1;
            end
            phase_next = PH_SKIP_NAME;
            acc_next   = '0;
            dlen_next  = rtp_pkg::DlenReset;
            doct_next  = rtp_pkg::DoctReset;
            pnote_next = '0;
            poct_next  = '0;
            pdot_next  = 1'b0;
            stop_next  = 1'b0;
        end
        else if (!stop_reg)
        begin
            // At most four passes: the header checks fall through to the note length.
            for (int i = 0; i < 4; i++)
            begin
                if (redo)
                begin
                    redo = 1'b0;
                    term = 1'b0;
                    case (phase_next)
                        PH_SKIP_NAME:
                            if (song_char == rtp_pkg::ChColon) phase_next = PH_HDR_D;
                        PH_HDR_D:
                            if (song_char == rtp_pkg::ChD) phase_next = PH_D_EQ;
                            else
                            begin
                                phase_next = PH_HDR_O;
                                redo = 1'b1;
                            end
                        PH_D_EQ:
                        begin
                            acc_next   = '0;
                            phase_next = PH_D_VAL;
                        end
                        PH_D_VAL:
                            if (dig)
                            begin
                                acc_next = (prod > 14'(rtp_pkg::AccMax)) ? rtp_pkg::AccMax
                                                                         : prod[9:0];
                            end
                            else
                            begin
                                if (acc_next != '0)
                                    dlen_next = (acc_next > 10'(rtp_pkg::DlenMax))
                                              ? rtp_pkg::DlenMax : acc_next[7:0];
                                phase_next = PH_HDR_O;
                            end
                        PH_HDR_O:
                            if (song_char == rtp_pkg::ChO) phase_next = PH_O_EQ;
                            else
                            begin
                                phase_next = PH_HDR_B;
                                redo = 1'b1;
                            end
                        PH_O_EQ:
                            phase_next = PH_O_VAL;
                        PH_O_VAL:
                        begin
                            if (song_char >= rtp_pkg::ChThree && song_char <= rtp_pkg::ChSeven)
                                doct_next = dval;
                            phase_next = PH_O_SEP;
                        end
                        PH_O_SEP:
                            phase_next = PH_HDR_B;
                        PH_HDR_B:
                            if (song_char == rtp_pkg::ChB) phase_next = PH_B_EQ;
                            else
                            begin
                                acc_next   = '0;
                                phase_next = PH_N_LEN;
                                if (!keep_playing) stop_next = 1'b1;
                                else redo = 1'b1;
                            end
                        PH_B_EQ:
                        begin
                            acc_next   = '0;
                            phase_next = PH_B_VAL;
                        end
                        PH_B_VAL:
                            if (dig)
                            begin
                                acc_next = (prod > 14'(rtp_pkg::AccMax)) ? rtp_pkg::AccMax
                                                                         : prod[9:0];
                            end
                            else
                            begin
                                bpm_fire   = 1'b1;
                                acc_next   = '0;
                                phase_next = PH_N_LEN;
                                if (!keep_playing) stop_next = 1'b1;
                            end
                        PH_N_LEN:
                            if (dig)
                            begin
                                acc_next = (14'({4'b0000, acc_next} * 14'd10) + {10'd0, dval}
                                            > 14'(rtp_pkg::AccMax)) ? rtp_pkg::AccMax
                                         : 10'(acc_next * 10'd10 + {6'd0, dval});
                            end
                            else
                            begin
                                case (song_char)
                                    rtp_pkg::ChC: pnote_next = 4'd1;
                                    rtp_pkg::ChD: pnote_next = 4'd3;
                                    rtp_pkg::ChE: pnote_next = 4'd5;
                                    rtp_pkg::ChF: pnote_next = 4'd6;
                                    rtp_pkg::ChG: pnote_next = 4'd8;
                                    rtp_pkg::ChA: pnote_next = 4'd10;
                                    rtp_pkg::ChB: pnote_next = 4'd12;
                                    default:      pnote_next = 4'd0;
                                endcase
                                pdot_next  = 1'b0;
                                poct_next  = doct_next;
                                phase_next = PH_N_LETTER;
                            end
                        PH_N_LETTER:
                            if (song_char == rtp_pkg::ChHash)
                            begin
                                pnote_next = pnote_next + 4'd1;
                                phase_next = PH_N_SHARP;
                            end
                            else if (song_char == rtp_pkg::ChDot)
                            begin
                                pdot_next  = 1'b1;
                                phase_next = PH_N_DOT;
                            end
                            else if (dig)
                            begin
                                poct_next  = dval;
                                phase_next = PH_N_OCT;
                            end
                            else term = 1'b1;
                        PH_N_SHARP:
                            if (song_char == rtp_pkg::ChDot)
                            begin
                                pdot_next  = 1'b1;
                                phase_next = PH_N_DOT;
                            end
                            else if (dig)
                            begin
                                poct_next  = dval;
                                phase_next = PH_N_OCT;
                            end
                            else term = 1'b1;
                        PH_N_DOT:
                            if (dig)
                            begin
                                poct_next  = dval;
                                phase_next = PH_N_OCT;
                            end
                            else term = 1'b1;
                        default:
                            term = 1'b1;
                    endcase
                    if (term)
                    begin
                        // The note is taken as it stood before the ending character.
                        emit       = 1'b1;
                        acc_next   = '0;
                        phase_next = PH_N_LEN;
                        if (!keep_playing) stop_next = 1'b1;
                        else if (song_char != rtp_pkg::ChComma) redo = 1'b1;
                    end
                end
            end
        end
    end

    assign sts.need_div = emit || bpm_fire;
    assign sts.div_last = (cnt_reg == rtp_pkg::CntW'(rtp_pkg::DivBits - 1));
    assign sts.div_note = kind_note_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SKIP_NAME;
            acc_reg    <= '0;
            dlen_reg   <= rtp_pkg::DlenReset;
            doct_reg   <= rtp_pkg::DoctReset;
            whole_reg  <= rtp_pkg::WholeReset;
            pnote_reg  <= '0;
            poct_reg   <= '0;
            pdot_reg   <= 1'b0;
            stop_reg   <= 1'b0;
            offset_reg <= '0;
            kind_note_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                offset_reg <= cfg_offset;
            if (cmd.accept)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                dlen_reg  <= dlen_next;
                doct_reg  <= doct_next;
                pnote_reg <= pnote_next;
                poct_reg  <= poct_next;
                pdot_reg  <= pdot_next;
                stop_reg  <= stop_next;
                cnt_reg   <= '0;
                kind_note_reg <= emit;
                if (end_of_song)
                    whole_reg <= rtp_pkg::WholeReset;
            end
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.finish && !kind_note_reg)
                whole_reg <= {quo_reg[rtp_pkg::WholeW-3:0], 2'b00};
        end
    end

    // Restoring divider, one quotient bit per step; the quotient shifts in
    // behind the dividend.
    logic [rtp_pkg::AccW:0] trial;
    assign trial = {rem_reg, quo_reg[rtp_pkg::WholeW-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rem_reg   <= '0;
            odot_reg  <= e_dot;
            onote_reg <= e_note;
            ooct_reg  <= {1'b0, e_oct} + {2'b00, offset_reg};
            olast_reg <= emit_last;
            if (emit)
            begin
                quo_reg  <= whole_reg;
                dvsr_reg <= e_len;
            end
            else
            begin
                quo_reg  <= rtp_pkg::MsPerMinute;
                dvsr_reg <= (bpm_val == '0) ? rtp_pkg::AccW'(1) : bpm_val;
            end
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, dvsr_reg})
            begin
                rem_reg <= rtp_pkg::AccW'(trial - {1'b0, dvsr_reg});
                quo_reg <= {quo_reg[rtp_pkg::WholeW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[rtp_pkg::AccW-1:0];
                quo_reg <= {quo_reg[rtp_pkg::WholeW-2:0], 1'b0};
            end
        end
        if (cmd.finish && kind_note_reg)
            odur_reg <= {1'b0, quo_reg} +
                        (odot_reg ? {2'b00, quo_reg[rtp_pkg::WholeW-1:1]} : '0);
    end

    assign note_code   = onote_reg;
    assign octave      = ooct_reg;
    assign duration_ms = odur_reg;
    assign last_note   = olast_reg;

endmodule

[sv/rtp_ctrl.sv]
// Controller of the ringtone parser: sequences accept, divide, finish
// and result hand-off. Depends on rtp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rtp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output rtp_pkg::rtp_cmd_t  cmd,
    input  rtp_pkg::rtp_sts_t  sts
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_FIN  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_OUT);
    assign cmd.accept   = in_valid && in_ready;
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.finish   = (state_reg == ST_FIN);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (cmd.accept && sts.need_div) state_next = ST_DIV;
            ST_DIV:
                if (sts.div_last) state_next = ST_FIN;
            ST_FIN:
                state_next = sts.div_note ? ST_OUT : ST_IDLE;
            ST_OUT:
                if (out_ready) state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `RTP_ASSERT(a_no_overlap, !(in_ready && out_valid))
    `RTP_ASSERT_NXT(a_div_start, cmd.accept && sts.need_div, state_reg == ST_DIV)
    `RTP_ASSERT_NXT(a_note_out, cmd.finish && sts.div_note, out_valid)
    `RTP_ASSERT_IMP(a_fin_after_div, cmd.finish, $past(sts.div_last))

endmodule

[sv/ringtone_text_note_parser_unit.sv]
// Top level of the ringtone text note parser: controller and datapath.
// Depends on rtp_pkg, rtp_ifs, rtp_ctrl and rtp_dp.
//
//  Channel    Dir  Payload                                       Handshake
//  song_in    in   song_char, end_of_song, keep_playing          valid/ready
//  note_out   out  note_code, octave, duration_ms, last_note     valid/ready
//  cfg        in   oct_shift                                     valid/ready
//
// A character that yields no note and no tempo change needs only the accept step.
// A character that ends the bpm digits starts the 18-step restoring divider:
// it is accepted, divided in ST_DIV and finished in ST_FIN.
// A character that ends a note takes the same steps and then waits in ST_OUT
// with the note on note_out until the receiver takes it.
// One item is in work at a time.
// Reset (rst_n low, asynchronous) returns the parser to name skipping with
// length 4, octave 6, bpm 63, and clears the octave offset.
// The configuration write is always ready.
module ringtone_text_note_parser_unit (
    input logic       clk,
    input logic       rst_n,
    rtp_in_if.sink    song_in,
    rtp_out_if.source note_out,
    rtp_cfg_if.sink   cfg
);

    rtp_pkg::rtp_cmd_t cmd;
    rtp_pkg::rtp_sts_t sts;

    // Offset writes are taken in any cycle; the user must make them arrive only while idle, unchecked by the block.
    assign cfg.ready = 1'b1;

    rtp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (song_in.valid),
        .in_ready  (song_in.ready),
        .out_valid (note_out.valid),
        .out_ready (note_out.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    rtp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .song_char    (song_in.song_char),
        .end_of_song  (song_in.end_of_song),
        .keep_playing (song_in.keep_playing),
        .cfg_we       (cfg.valid),
        .cfg_offset   (cfg.oct_shift),
        .note_code    (note_out.note_code),
        .octave       (note_out.octave),
        .duration_ms  (note_out.duration_ms),
        .last_note    (note_out.last_note)
    );

endmodule

[verif/ringtone_text_note_parser_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench of the ringtone text note parser: directed and random ringtone texts.
// Depends on rtp_pkg, the channel interfaces in rtp_ifs and the parser top level.
module ringtone_text_note_parser_unit_tb;

    // Parse phases of the predictor. They follow the order in which the
    // text is read: name, the three header fields, then the note fields.
    typedef enum logic [3:0] {
        PS_NAME, PS_D_KEY, PS_D_EQ, PS_D_NUM, PS_O_KEY, PS_O_EQ, PS_O_NUM, PS_O_SEP,
        PS_B_KEY, PS_B_EQ, PS_B_NUM, PS_LEN, PS_LETTER, PS_SHARP, PS_DOT, PS_OCT
    } parse_state_e;

    typedef struct packed {
        logic [rtp_pkg::NoteW-1:0]   note_code;
        logic [rtp_pkg::OutOctW-1:0] octave;
        logic [rtp_pkg::DurW-1:0]    duration_ms;
        logic                        last_note;
    } note_result_t;

    // The scoreboard holds a copy of the parser state, works out the note
    // that each accepted character causes and checks the notes that come out.
    class note_scoreboard;
        note_result_t   expected_notes[$];
        int             fails;
        logic [2:0]     offset;
        parse_state_e   phase;
        int unsigned    acc;
        int unsigned    dlen;
        int unsigned    doct;
        int unsigned    whole_ms;
        int unsigned    pnote;
        int unsigned    poct;
        bit             pdot;
        bit             halted;

        function new();
            fails  = 0;
            offset = '0;
            restart();
        endfunction

        function void restart();
            phase    = PS_NAME;
            acc      = 0;
            dlen     = 4;
            doct     = 6;
            whole_ms = 3808;
            pnote    = 0;
            poct     = 0;
            pdot     = 0;
            halted   = 0;
        endfunction

        function int unsigned whole_of_bpm(int unsigned bpm);
            if (bpm == 0)
                return 240000;
            return (60000 / bpm) * 4;
        endfunction

        function void add_digit(byte unsigned c);
            int unsigned v;
            v = acc * 10 + (c - "0");
            acc = (v > 1023) ? 1023 : v;
        endfunction

        function void push_note(bit last);
            int unsigned  len;
            int unsigned  dur;
            note_result_t r;
            len = (acc != 0) ? acc : dlen;
            if (len == 0)
                len = 1;
            dur = whole_ms / len;
            if (pdot)
                dur = dur + dur / 2;
            r.note_code   = pnote[3:0];
            r.octave      = poct[4:0] + {2'b00, offset};
            r.duration_ms = dur[18:0];
            r.last_note   = last;
            expected_notes.push_back(r);
        endfunction

        // Called for each accepted input transaction.
        function void note_char(byte unsigned c, bit eos, bit kp);
            bit isdig;
            bit again;
            bit term;
            isdig = (c >= "0") && (c <= "9");
            if (eos)
            begin
                if (!halted && phase >= PS_LETTER)
                    push_note(1'b1);
                restart();
                return;
            end
            if (halted)
                return;
            again = 1;
            while (again)
            begin
                again = 0;
                term  = 0;
                case (phase)
                    PS_NAME:   if (c == ":") phase = PS_D_KEY;
                    PS_D_KEY:
                    begin
                        if (c == "d") phase = PS_D_EQ;
                        else begin phase = PS_O_KEY; again = 1; end
                    end
                    PS_D_EQ:   begin acc = 0; phase = PS_D_NUM; end
                    PS_D_NUM:
                    begin
                        if (isdig) add_digit(c);
                        else
                        begin
                            if (acc > 0) dlen = (acc > 255) ? 255 : acc;
                            phase = PS_O_KEY;
                        end
                    end
                    PS_O_KEY:
                    begin
                        if (c == "o") phase = PS_O_EQ;
                        else begin phase = PS_B_KEY; again = 1; end
                    end
                    PS_O_EQ:   phase = PS_O_NUM;
                    PS_O_NUM:
                    begin
                        if (c >= "3" && c <= "7") doct = c - "0";
                        phase = PS_O_SEP;
                    end
                    PS_O_SEP:  phase = PS_B_KEY;
                    PS_B_KEY:
                    begin
                        if (c == "b") phase = PS_B_EQ;
                        else
                        begin
                            acc   = 0;
                            phase = PS_LEN;
                            if (!kp) halted = 1;
                            else again = 1;
                        end
                    end
                    PS_B_EQ:   begin acc = 0; phase = PS_B_NUM; end
                    PS_B_NUM:
                    begin
                        if (isdig) add_digit(c);
                        else
                        begin
                            whole_ms = whole_of_bpm(acc);
                            acc      = 0;
                            phase    = PS_LEN;
                            if (!kp) halted = 1;
                        end
                    end
                    PS_LEN:
                    begin
                        if (isdig) add_digit(c);
                        else
                        begin
                            case (c)
                                "c": pnote = 1;
                                "d": pnote = 3;
                                "e": pnote = 5;
                                "f": pnote = 6;
                                "g": pnote = 8;
                                "a": pnote = 10;
                                "b": pnote = 12;
                                default: pnote = 0;
                            endcase
                            pdot  = 0;
                            poct  = doct;
                            phase = PS_LETTER;
                        end
                    end
                    PS_LETTER:
                    begin
                        if (c == "#") begin pnote = pnote + 1; phase = PS_SHARP; end
                        else if (c == ".") begin pdot = 1; phase = PS_DOT; end
                        else if (isdig) begin poct = c - "0"; phase = PS_OCT; end
                        else term = 1;
                    end
                    PS_SHARP:
                    begin
                        if (c == ".") begin pdot = 1; phase = PS_DOT; end
                        else if (isdig) begin poct = c - "0"; phase = PS_OCT; end
                        else term = 1;
                    end
                    PS_DOT:
                    begin
                        if (isdig) begin poct = c - "0"; phase = PS_OCT; end
                        else term = 1;
                    end
                    default:   term = 1;
                endcase
                // A character that cannot continue the note closes it; anything
                // but a comma is then looked at again as the start of a new note.
                if (term)
                begin
                    push_note(1'b0);
                    acc   = 0;
                    phase = PS_LEN;
                    if (!kp) halted = 1;
                    else if (c != ",") again = 1;
                end
            end
        endfunction

        // Called for each accepted output transaction.
        function void check_note(note_result_t got);
            note_result_t want;
            if (expected_notes.size() == 0)
            begin
                $display("%0t: unexpected note, expected none, actual %p", $realtime, got);
                fails++;
                return;
            end
            want = expected_notes.pop_front();
            if (got.note_code !== want.note_code)
            begin
                $display("%0t: note_code expected %0d actual %0d",
                         $realtime, want.note_code, got.note_code);
                fails++;
            end
            if (got.octave !== want.octave)
            begin
                $display("%0t: octave expected %0d actual %0d",
                         $realtime, want.octave, got.octave);
                fails++;
            end
            if (got.duration_ms !== want.duration_ms)
            begin
                $display("%0t: duration_ms expected %0d actual %0d",
                         $realtime, want.duration_ms, got.duration_ms);
                fails++;
            end
            if (got.last_note !== want.last_note)
            begin
                $display("%0t: last_note expected %0d actual %0d",
                         $realtime, want.last_note, got.last_note);
                fails++;
            end
        endfunction
    endclass

    localparam int WatchdogLimit = 3000;
    localparam int HoldCycles    = 400;
    localparam int ItemBudget    = 1150;

    logic clk;
    logic rst_n;

    rtp_in_if  song_in ();
    rtp_out_if note_out ();
    rtp_cfg_if cfg ();

    ringtone_text_note_parser_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .song_in  (song_in.sink),
        .note_out (note_out.source),
        .cfg      (cfg.sink)
    );

    note_scoreboard sb = new();

    int  chars_sent   = 0;
    int  idle_cycles  = 0;
    bit  hold_request = 0;
    byte unsigned text[$];

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Monitors: all sample the handshakes at the rising edge, where the
    // values seen are those that the edge accepts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (song_in.valid && song_in.ready)
                sb.note_char(song_in.song_char, song_in.end_of_song, song_in.keep_playing);
            if (cfg.valid && cfg.ready)
                sb.offset = cfg.oct_shift;
            if (note_out.valid && note_out.ready)
                sb.check_note({note_out.note_code, note_out.octave,
                               note_out.duration_ms, note_out.last_note});
        end
    end

    // Watchdog: a long run of cycles with no transaction on any channel means
    // the block has hung.
    always @(posedge clk)
    begin
        if ((song_in.valid && song_in.ready) || (note_out.valid && note_out.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: a random wait before each note, and on request one long
    // hold-off so that the parser fills up and stalls its input.
    initial
    begin
        int gap;
        note_out.ready <= 1'b0;
        @(posedge clk);
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 0;
                note_out.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                note_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            note_out.ready <= 1'b1;
            do @(posedge clk); while (!note_out.valid);
        end
    end

    // Offers one character transaction after a random gap. valid stays high
    // into the next transaction when that one has no gap.
    task automatic send_char(byte unsigned c, bit eos, bit kp);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            song_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        song_in.valid        <= 1'b1;
        song_in.song_char    <= c;
        song_in.end_of_song  <= eos;
        song_in.keep_playing <= kp;
        do @(posedge clk); while (!song_in.ready);
        chars_sent++;
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endfunction

    // Sends the buffered text, then the end-of-song mark. Each character
    // breaks with a chance of break_pct percent, low in the random tests.
    task automatic play_text(int break_pct);
        byte unsigned c;
        while (text.size() > 0)
        begin
            c = text.pop_front();
            send_char(c, 1'b0, ($urandom_range(0, 99) >= break_pct));
        end
        send_char(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)));
    endtask

    function automatic string pick_number();
        case ($urandom_range(0, 7))
            0: return "0";
            1: return "1";
            2: return "255";
            3: return "99999";
            4: return $sformatf("%0d", $urandom_range(0, 1023));
            default: return $sformatf("%0d", 1 << $urandom_range(0, 5));
        endcase
    endfunction

    // Builds a random ringtone text: name, some of the header fields and a
    // few notes with random fields.
    function automatic void build_song();
        string letters;
        int    notes;
        letters = "cdefgabp";
        repeat ($urandom_range(0, 4))
            text.push_back(8'($urandom_range(8'h61, 8'h7A)));
        text.push_back(rtp_pkg::ChColon);
        if ($urandom_range(0, 2) != 0)
            add_text({"d=", pick_number(), ","});
        if ($urandom_range(0, 2) != 0)
        begin
            add_text("o=");
            text.push_back(8'($urandom_range(8'h30, 8'h39)));
            text.push_back(rtp_pkg::ChComma);
        end
        if ($urandom_range(0, 2) != 0)
            add_text({"b=", pick_number(), ":"});
        notes = $urandom_range(1, 8);
        for (int n = 0; n < notes; n++)
        begin
            if ($urandom_range(0, 1) != 0)
                add_text(pick_number());
            if ($urandom_range(0, 9) == 0)
                text.push_back(8'($urandom_range(0, 255)));
            else
                text.push_back(letters[$urandom_range(0, 7)]);
            if ($urandom_range(0, 3) == 0) text.push_back(rtp_pkg::ChHash);
            if ($urandom_range(0, 3) == 0) text.push_back(rtp_pkg::ChDot);
            if ($urandom_range(0, 2) == 0) text.push_back(8'($urandom_range(8'h30, 8'h39)));
            if (n != notes - 1)
                text.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                           : rtp_pkg::ChComma);
        end
    endfunction

    // Waits until every expected note has come out, then lets the divider
    // finish any tempo change that produced no note.
    task automatic wait_idle();
        song_in.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_notes.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_offset(logic [2:0] value);
        cfg.valid     <= 1'b1;
        cfg.oct_shift <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        logic [2:0] offsets[4];
        rst_n                = 1'b0;
        song_in.valid        <= 1'b0;
        song_in.song_char    <= '0;
        song_in.end_of_song  <= 1'b0;
        song_in.keep_playing <= 1'b1;
        cfg.valid            <= 1'b0;
        cfg.oct_shift        <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts: extreme header values, zero bpm, saturation, sharp
        // rest, unknown letters, a zero default length and a break.
        write_offset(3'd7);
        add_text("ab:d=255,o=7,b=0:1c,32c#.4,p#,h,B,,d.9,9999g");
        play_text(0);
        add_text(":d=0,o=2,b=1023:a");
        play_text(0);
        add_text(":x4");
        play_text(0);
        add_text(":b=99:e,f");
        play_text(100);
        wait_idle();

        offsets[0] = 3'd0;
        offsets[1] = 3'd3;
        offsets[2] = 3'd7;
        offsets[3] = 3'($urandom_range(0, 7));
        for (int p = 0; p < 4; p++)
        begin
            write_offset(offsets[p]);
            // The second part always starts with one long hold-off.
            if (p == 1)
                hold_request = 1;
            while (chars_sent < ItemBudget * (p + 1) / 4)
            begin
                if (p == 1 && !hold_request && $urandom_range(0, 20) == 0)
                    hold_request = 1;
                if ($urandom_range(0, 9) == 0)
                begin
                    // Noise: arbitrary bytes, sometimes ended mid-text.
                    repeat ($urandom_range(1, 12))
                        text.push_back(8'($urandom_range(0, 255)));
                end
                else
                    build_song();
                play_text(3);
            end
            wait_idle();
        end

        repeat (60) @(posedge clk);
        if (sb.fails == 0 && sb.expected_notes.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
